// ===== rtl/core/aabb_frustum_cull_compact_macros.svh =====
// Assertion helpers shared by the culling block.
`ifndef AABB_FRUSTUM_CULL_COMPACT_MACROS_SVH
`define AABB_FRUSTUM_CULL_COMPACT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afc assertion failed");

// Next-cycle implication, checked outside reset.
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afc assertion failed");

`endif

// ===== rtl/core/afc_pkg.sv =====
package afc_pkg;

    localparam int PLANE_COUNT   = 6;
    localparam int MAX_INSTANCES = 4096;
    localparam int AXES          = 3;

    localparam int COORD_W  = 16;
    localparam int CORNER_W = COORD_W + 1;
    localparam int PROD_W   = COORD_W + CORNER_W;
    localparam int SUM_W    = PROD_W + 3;
    localparam int FRAC_SHIFT = 14;

    localparam int CNT_W  = 13;
    localparam int SLOT_W = 12;

    localparam int CFG_AW = 3;
    localparam int CFG_W  = 64;
    localparam int BOX_W  = 48;

    localparam logic [CFG_AW-1:0] REG_BOX_MIN = 3'd6;
    localparam logic [CFG_AW-1:0] REG_BOX_MAX = 3'd7;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    localparam int FLIGHT_W   = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic   visible;
        logic   last;
        coord_t z;
        coord_t y;
        coord_t x;
    } afc_entry_t;

    typedef struct packed {
        logic              visible;
        logic [SLOT_W-1:0] slot;
        coord_t            x;
        coord_t            y;
        coord_t            z;
        logic              frame_end;
        logic [CNT_W-1:0]  kept_total;
    } afc_result_t;

    // Pick one signed 16-bit lane out of a packed register.
    function automatic coord_t lane16(input logic [CFG_W-1:0] word, input logic [1:0] idx);
        return coord_t'(word[16*idx +: 16]);
    endfunction

endpackage

// ===== rtl/core/aabb_frustum_cull_compact.sv =====
// Frustum culling of a shared bounding box per instance, with slot compaction.
// Input stream (s_axis): one word per instance position; tlast closes the frame.
// Output stream (m_axis): one word per input word, in order: visibility in
// tuser, compacted slot, passed-through position and running visible total.
// Configuration: write cfg_we with cfg_addr 0..5 for the six planes, 6 for
// the box minimum and 7 for the box maximum; only while the block is idle.
// Pipeline: a word accepted on s_axis passes three plane-test stages, a queue
// write and an output register load. Throughput: one word per cycle while
// s_axis_tready is high. The front accepts whenever the queue has room for
// the new word and every word in the three test stages; the queue holds eight.
// The back pops one word a cycle into the output register while it is empty
// or being taken, and the visible counter is the only thing linking words.
// When the receiver stalls, the output word holds, the queue fills and
// s_axis_tready drops once in-flight words would fill it.
// Reset clears planes, box, counter, queue and all valid flags; nothing
// needs a clearing pass. The visible count saturates at 4096 and is cleared
// after the frame's last word.
`include "aabb_frustum_cull_compact_macros.svh"

module aabb_frustum_cull_compact
    import afc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
    input  logic                s_axis_tlast,   // last_item
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [79:0]         m_axis_tdata,   // slot[11:0], out_x[27:12], out_y[43:28],
                                                // out_z[59:44], kept_total[72:60], zero pad
    output logic                m_axis_tuser,   // visible
    output logic                m_axis_tlast    // frame_end
);

    logic                in_accept;
    logic                push;
    afc_entry_t          push_entry;
    logic [FLIGHT_W-1:0] inflight;
    logic                pop;
    afc_entry_t          pop_entry;
    logic                q_not_empty;
    logic [FIFO_CW-1:0]  q_count;
    afc_result_t         result;

    // Admit a word only if every word already in the test stages still fits.
    assign s_axis_tready = (5'(q_count) + 5'(inflight)) < 5'(FIFO_DEPTH);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    afc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_accept),
        .in_x       (coord_t'(s_axis_tdata[15:0])),
        .in_y       (coord_t'(s_axis_tdata[31:16])),
        .in_z       (coord_t'(s_axis_tdata[47:32])),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry),
        .inflight   (inflight)
    );

    afc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    afc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_entry     (pop_entry),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    // Pack the result word.
    assign m_axis_tdata = {7'd0, result.kept_total, result.z, result.y, result.x, result.slot};
    assign m_axis_tuser = result.visible;
    assign m_axis_tlast = result.frame_end;

    // The queue never takes a word it has no room for.
    `AFC_ASSERT_NOW(a_no_overflow, clk, rst_n, push && !pop, q_count < FIFO_CW'(FIFO_DEPTH))
    // A culled word always carries slot zero.
    `AFC_ASSERT_NOW(a_culled_slot, clk, rst_n, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tdata[11:0] == 12'd0)
    // The running total never passes the saturation limit.
    `AFC_ASSERT_NOW(a_total_sat, clk, rst_n, m_axis_tvalid,
                    m_axis_tdata[72:60] <= 13'(MAX_INSTANCES))
    // A word taken from the queue is presented on the next cycle.
    `AFC_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, m_axis_tvalid)

endmodule

// ===== rtl/core/afc_front.sv =====
module afc_front
    import afc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    input  coord_t              in_x,
    input  coord_t              in_y,
    input  coord_t              in_z,
    input  logic                in_last,
    output logic                push,
    output afc_entry_t          push_entry,
    output logic [FLIGHT_W-1:0] inflight
);

    logic [CFG_W-1:0] plane_reg [PLANE_COUNT];
    logic [BOX_W-1:0] box_min_reg;
    logic [BOX_W-1:0] box_max_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic last1_reg, last2_reg;
    coord_t pos1_reg [AXES];
    coord_t pos2_reg [AXES];
    logic signed [CORNER_W-1:0] corner_reg [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0]   prod_reg   [PLANE_COUNT][AXES];
    afc_entry_t entry_reg;

    coord_t in_pos [AXES];
    logic signed [CORNER_W-1:0] corner_next [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0]   prod_next   [PLANE_COUNT][AXES];
    logic [PLANE_COUNT-1:0]     cull;
    logic signed [SUM_W-1:0]    sum [PLANE_COUNT];

    assign in_pos[0] = in_x;
    assign in_pos[1] = in_y;
    assign in_pos[2] = in_z;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                plane_reg[p] <= '0;
            end
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                if (cfg_addr == CFG_AW'(p))
                begin
                    plane_reg[p] <= cfg_wdata;
                end
            end
            if (cfg_addr == REG_BOX_MIN)
            begin
                box_min_reg <= cfg_wdata[BOX_W-1:0];
            end
            if (cfg_addr == REG_BOX_MAX)
            begin
                box_max_reg <= cfg_wdata[BOX_W-1:0];
            end
        end
    end

    // Stage 1: farthest corner per plane and axis, offset by the position
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (lane16(plane_reg[p], 2'(a)) < 0)
                begin
                    corner_next[p][a] = CORNER_W'(lane16(CFG_W'(box_min_reg), 2'(a)))
                                      + CORNER_W'(in_pos[a]);
                end
                else
                begin
                    corner_next[p][a] = CORNER_W'(lane16(CFG_W'(box_max_reg), 2'(a)))
                                      + CORNER_W'(in_pos[a]);
                end
            end
        end
    end

    // Stage 2: normal times corner
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prod_next[p][a] = PROD_W'(lane16(plane_reg[p], 2'(a))) * PROD_W'(corner_reg[p][a]);
            end
        end
    end

    // Stage 3: plane distance sign
    always_comb
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            sum[p] = (SUM_W'(lane16(plane_reg[p], 2'd3)) <<< FRAC_SHIFT)
                   + SUM_W'(prod_reg[p][0]) + SUM_W'(prod_reg[p][1]) + SUM_W'(prod_reg[p][2]);
            cull[p] = sum[p][SUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXES; a++)
        begin
            pos1_reg[a] <= in_pos[a];
            pos2_reg[a] <= pos1_reg[a];
        end
        last1_reg <= in_last;
        last2_reg <= last1_reg;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                corner_reg[p][a] <= corner_next[p][a];
                prod_reg[p][a]   <= prod_next[p][a];
            end
        end
        entry_reg.visible <= ~|cull;
        entry_reg.last    <= last2_reg;
        entry_reg.x       <= pos2_reg[0];
        entry_reg.y       <= pos2_reg[1];
        entry_reg.z       <= pos2_reg[2];
    end

    assign push       = v3_reg;
    assign push_entry = entry_reg;
    assign inflight   = FLIGHT_W'(v1_reg) + FLIGHT_W'(v2_reg) + FLIGHT_W'(v3_reg);

endmodule

// ===== rtl/core/afc_fifo.sv =====
module afc_fifo
    import afc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  afc_entry_t         push_entry,
    input  logic               pop,
    output afc_entry_t         pop_entry,
    output logic               not_empty,
    output logic [FIFO_CW-1:0] count
);

    afc_entry_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== rtl/core/afc_back.sv =====
module afc_back
    import afc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  afc_entry_t  q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output afc_result_t out_result
);

    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] kept_after;
    logic             out_valid_reg;
    afc_result_t      result_reg, result_next;

    // Take a word whenever the output register is free or being drained.
    assign q_pop = q_not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        kept_after = kept_reg;
        result_next.slot = '0;
        if (q_entry.visible)
        begin
            if (kept_reg < CNT_W'(MAX_INSTANCES))
            begin
                result_next.slot = kept_reg[SLOT_W-1:0];
                kept_after       = kept_reg + 1'b1;
            end
            else
            begin
                result_next.slot = SLOT_W'(MAX_INSTANCES - 1);
            end
        end
        result_next.visible    = q_entry.visible;
        result_next.x          = q_entry.x;
        result_next.y          = q_entry.y;
        result_next.z          = q_entry.z;
        result_next.frame_end  = q_entry.last;
        result_next.kept_total = kept_after;
        kept_next = q_entry.last ? '0 : kept_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                kept_reg      <= kept_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

// ===== bench/aabb_frustum_cull_compact_tb.sv =====
module aabb_frustum_cull_compact_tb;
    import afc_pkg::*;

    // Plane registers sit at consecutive addresses from here; box corners use
    // the package addresses.
    localparam logic [CFG_AW-1:0] REG_PLANE0 = 3'd0;

    localparam int IDLE_MAX       = 12;
    localparam int HOLD_OFF       = 100;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_ITEMS    = 80;

    // One predicted output word, field by field.
    typedef struct packed {
        logic              visible;
        logic [SLOT_W-1:0] slot;
        coord_t            x;
        coord_t            y;
        coord_t            z;
        logic              frame_end;
        logic [CNT_W-1:0]  kept_total;
    } cull_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              cfg_we        = 1'b0;
    logic [CFG_AW-1:0] cfg_addr      = '0;
    logic [CFG_W-1:0]  cfg_wdata     = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [79:0]       m_axis_tdata;
    logic              m_axis_tuser;
    logic              m_axis_tlast;

    // Shadow of the block's registers and visible counter.
    logic [CFG_W-1:0]  plane_reg [PLANE_COUNT];
    logic [CFG_W-1:0]  box_min_word;
    logic [CFG_W-1:0]  box_max_word;
    logic [CNT_W-1:0]  visible_count = '0;

    // Words still owed by the block, oldest first.
    cull_result_t      pending_results [$];

    int                error_count       = 0;
    int                send_idle_max     = 0;
    int                recv_idle_max     = 0;
    int                recv_hold_cycles  = 0;

    aabb_frustum_cull_compact i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pos_x[15:0], pos_y[31:16], pos_z[47:32]
        .s_axis_tlast  (s_axis_tlast),   // last_item
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // slot[11:0], out_x[27:12], out_y[43:28],
                                         // out_z[59:44], kept_total[72:60], zero pad
        .m_axis_tuser  (m_axis_tuser),   // visible
        .m_axis_tlast  (m_axis_tlast)    // frame_end
    );

    always #4 clk = ~clk;

    // Bound the run in case the block locks up.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Compute the expected word for one accepted position and advance the
    // shadow counter. Each plane tests the box corner farthest along its
    // normal: min corner for a negative component, max corner otherwise.
    function automatic cull_result_t predict_cull(input coord_t px, input coord_t py,
                                                  input coord_t pz, input logic last);
        cull_result_t      r;
        logic [47:0]       pos_word;
        longint            acc;
        longint            n;
        longint            corner;
        logic              culled;
        pos_word = {pz, py, px};
        culled   = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            acc = longint'($signed(plane_reg[p][63:48])) * (longint'(1) << FRAC_SHIFT);
            for (int a = 0; a < AXES; a++)
            begin
                n = longint'($signed(plane_reg[p][16*a +: 16]));
                if (n < 0)
                    corner = longint'($signed(box_min_word[16*a +: 16]));
                else
                    corner = longint'($signed(box_max_word[16*a +: 16]));
                corner = corner + longint'($signed(pos_word[16*a +: 16]));
                acc    = acc + n * corner;
            end
            if (acc < 0)
                culled = 1'b1;
        end
        r.visible = !culled;
        r.slot    = '0;
        if (!culled)
        begin
            // Saturate: a full counter hands out the top slot again.
            if (visible_count < MAX_INSTANCES)
            begin
                r.slot        = visible_count[SLOT_W-1:0];
                visible_count = visible_count + 1'b1;
            end
            else
                r.slot = SLOT_W'(MAX_INSTANCES - 1);
        end
        r.x          = px;
        r.y          = py;
        r.z          = pz;
        r.frame_end  = last;
        r.kept_total = visible_count;
        if (last)
            visible_count = '0;
        return r;
    endfunction

    function automatic coord_t rand_coord();
        // Bias a quarter of the draws near the origin so box edges matter.
        if ($urandom_range(3, 0) == 0)
            return coord_t'(int'($urandom_range(1023, 0)) - 512);
        return coord_t'($urandom);
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare every output word with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        cull_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("visible", longint'(want.visible), longint'(m_axis_tuser));
                check_field("slot", longint'(want.slot), longint'(m_axis_tdata[11:0]));
                check_field("out_x", longint'(want.x),
                            longint'($signed(m_axis_tdata[27:12])));
                check_field("out_y", longint'(want.y),
                            longint'($signed(m_axis_tdata[43:28])));
                check_field("out_z", longint'(want.z),
                            longint'($signed(m_axis_tdata[59:44])));
                check_field("frame_end", longint'(want.frame_end), longint'(m_axis_tlast));
                check_field("kept_total", longint'(want.kept_total),
                            longint'(m_axis_tdata[72:60]));
            end
        end
    end

    // Output side: stall a random number of cycles before each word, and
    // honor a long hold-off when a test asks for one.
    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(recv_idle_max, 0) + recv_hold_cycles;
            recv_hold_cycles = 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Offer one position word; predict its result once the block takes it.
    // Leave tvalid high so back-to-back words stream without a bubble.
    task automatic offer_position(input coord_t px, input coord_t py, input coord_t pz,
                                  input logic last);
        int gap;
        gap = $urandom_range(send_idle_max, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pz, py, px};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_cull(px, py, pz, last));
    endtask

    // Drop tvalid and hold until every expected word has come out.
    task automatic await_drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Write all eight registers from the shadow; call only while idle.
    task automatic load_registers();
        logic [CFG_AW-1:0] idx;
        for (int r = 0; r < PLANE_COUNT + 2; r++)
        begin
            idx = REG_PLANE0 + CFG_AW'(r);
            cfg_we   <= 1'b1;
            cfg_addr <= idx;
            if (idx == REG_BOX_MIN)
                cfg_wdata <= box_min_word;
            else if (idx == REG_BOX_MAX)
                cfg_wdata <= box_max_word;
            else
                cfg_wdata <= plane_reg[idx];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        box_min_word = box_min_word[BOX_W-1:0];
        box_max_word = box_max_word[BOX_W-1:0];
    endtask

    // Random box and a few random planes; the rest stay zero and never cull.
    task automatic pick_planes(input int active);
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_reg[p] = '0;
        for (int k = 0; k < active; k++)
            plane_reg[$urandom_range(PLANE_COUNT - 1, 0)] = {$urandom, $urandom};
        box_min_word = {$urandom, $urandom};
        box_max_word = {$urandom, $urandom};
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            offer_position(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
    endtask

    // Reset values: no plane culls, so every word is visible.
    task automatic test_reset_state();
        send_idle_max = 3;
        recv_idle_max = 3;
        offer_position(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
        offer_position(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1);
        offer_position(16'h0000, 16'h0000, 16'h0000, 1'b1);
    endtask

    // Planes facing +x and -y around a box from -0x40 to 0x40: probe both
    // sides of each boundary; the zero components pick the max corner.
    task automatic test_plane_sides();
        await_drain();
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_reg[p] = '0;
        plane_reg[0] = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
        plane_reg[1] = {16'h0000, 16'h0000, 16'hC000, 16'h0000};
        box_min_word = {16'h0000, 16'hFFC0, 16'hFFC0, 16'hFFC0};
        box_max_word = {16'h0000, 16'h0040, 16'h0040, 16'h0040};
        load_registers();
        offer_position(16'hFFC0, 16'h0000, 16'h0000, 1'b0);
        offer_position(16'hFFBF, 16'h0000, 16'h0000, 1'b0);
        offer_position(16'h0000, 16'h0040, 16'h0000, 1'b0);
        offer_position(16'h0000, 16'h0041, 16'h0000, 1'b1);
    endtask

    // Min corner above max, taken as given; extreme normals, constants and
    // positions.
    task automatic test_reversed_box();
        await_drain();
        plane_reg[0] = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
        plane_reg[1] = '0;
        plane_reg[4] = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        plane_reg[5] = {16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
        box_min_word = {16'hFFFF, 16'h0040, 16'h0040, 16'h0040};
        box_max_word = {16'hFFFF, 16'hFFC0, 16'hFFC0, 16'hFFC0};
        load_registers();
        offer_position(16'h0040, 16'h0000, 16'h0000, 1'b0);
        offer_position(16'h003F, 16'h0000, 16'h0000, 1'b0);
        offer_position(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        offer_position(16'h8000, 16'h8000, 16'h8000, 1'b0);
        offer_position(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1);
    endtask

    // Stall the output long enough to fill the queue while words keep coming,
    // pause the input until everything is out, then send a frame with idling.
    task automatic test_backpressure();
        await_drain();
        pick_planes(1);
        load_registers();
        send_idle_max    = 0;
        recv_idle_max    = 0;
        recv_hold_cycles = HOLD_OFF;
        send_frame(40);
        await_drain();
        send_idle_max = IDLE_MAX;
        recv_idle_max = IDLE_MAX;
        send_frame(20);
    endtask

    // Random frames under one register setting and one idling mix.
    task automatic test_random_phase(input int phase);
        int sent;
        int len;
        await_drain();
        case (phase)
            0:
            begin
                pick_planes(0);
                send_idle_max = 0;
                recv_idle_max = 0;
            end
            1:
            begin
                for (int p = 0; p < PLANE_COUNT; p++)
                    plane_reg[p] = '1;
                box_min_word  = '1;
                box_max_word  = '1;
                send_idle_max = IDLE_MAX;
                recv_idle_max = IDLE_MAX;
            end
            2:
            begin
                pick_planes(2);
                box_min_word  = {16'hFFFF, 16'h8000, 16'h8000, 16'h8000};
                box_max_word  = {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                send_idle_max = 0;
                recv_idle_max = IDLE_MAX;
            end
            3:
            begin
                pick_planes(PLANE_COUNT);
                send_idle_max = IDLE_MAX;
                recv_idle_max = 0;
            end
            default:
            begin
                pick_planes($urandom_range(3, 1));
                send_idle_max = $urandom_range(IDLE_MAX, 0);
                recv_idle_max = $urandom_range(IDLE_MAX, 0);
            end
        endcase
        load_registers();
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            len = ($urandom_range(7, 0) == 0) ? 1 : $urandom_range(30, 2);
            send_frame(len);
            sent += len;
        end
    endtask

    initial
    begin
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_reg[p] = '0;
        box_min_word = '0;
        box_max_word = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_plane_sides();
        test_reversed_box();
        test_backpressure();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            test_random_phase(ph);

        // Drain, then watch a few more cycles for stray words.
        await_drain();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
